// ----- design/lce_pkg.sv -----
package lce_pkg;

	localparam int NUM_STRIPS = 4;
	localparam int NCH        = NUM_STRIPS * 4;
	localparam int CH_W       = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int LVL_W      = 12;
	localparam int DUR_W      = 16;
	localparam int PROD_W     = LVL_W + DUR_W;
	localparam int CNT_W      = $clog2(PROD_W + 1);
	localparam int PWM_W      = 13;
	localparam logic [LVL_W-1:0] LVL_MAX  = 12'd4095;
	localparam logic [PWM_W-1:0] FULL_BIT = 13'd4096;

	typedef enum logic [2:0] {
		REQ_TICK  = 3'd0,
		REQ_STRIP = 3'd1,
		REQ_ALL   = 3'd2,
		REQ_OFF   = 3'd3,
		REQ_PULSE = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		CFG_INVERT  = 2'd0,
		CFG_TIMEOUT = 2'd1,
		CFG_PERIOD  = 2'd2,
		CFG_LEVEL   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic             kind;
		logic [3:0]       channel;
		logic [PWM_W-1:0] on_count;
		logic [PWM_W-1:0] off_count;
		logic             solenoid_on;
		logic             last;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [PROD_W-1:0] dividend;
		logic [DUR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [LVL_W-1:0] quotient;
	} div_rsp_t;

	// Level to PWM word pair, with optional inversion.
	function automatic res_t pwm_word(input logic [CH_W-1:0] ch, input logic [LVL_W-1:0] lvl,
			input logic inv, input logic sol);
		logic [LVL_W-1:0] v;
		res_t r;
		v = inv ? ~lvl : lvl;
		r.kind = 1'b0;
		r.channel = 4'(ch);
		r.solenoid_on = sol;
		r.last = 1'b0;
		if (v == LVL_MAX) begin
			r.on_count = FULL_BIT;
			r.off_count = '0;
		end else if (v == '0) begin
			r.on_count = '0;
			r.off_count = FULL_BIT;
		end else begin
			r.on_count = '0;
			r.off_count = PWM_W'(v);
		end
		return r;
	endfunction

	// 8-bit to 12-bit scale: v*4095/255 equals 16*v + v/17, the latter by reciprocal.
	function automatic logic [LVL_W-1:0] scale8(input logic [7:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd241;
		return {v, 4'b0} + LVL_W'(p[15:12]);
	endfunction

endpackage

// ----- design/lce_div.sv -----
module lce_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lce_pkg::div_req_t req,
	output lce_pkg::div_rsp_t rsp
);
	import lce_pkg::*;

	logic [DUR_W:0]    rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [DUR_W-1:0]  div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DUR_W:0]    trial;

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q[DUR_W-1:0], quo_q[PROD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(PROD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial - {1'b0, div_q};
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q[LVL_W-1:0];

endmodule

// ----- design/led_crossfade_engine.sv -----
// LED crossfade engine: sixteen PWM channels for four RGBW strips plus one solenoid.
// Input channel: in_valid / in_stall carry one beat per tick or light command. A
// beat is taken only while the engine is idle; in_stall stays high for the whole
// service pass that follows it.
// Output channel: out_valid / out_stall carry one beat per PWM write or solenoid
// change, up to eighteen per input beat; the final beat of an input has last set.
// Pass order: the pass visits every channel in turn. An inactive channel is
// stepped past; an interpolating channel goes through the multiplier and then
// waits on the shared serial divider, which produces one quotient bit per cycle.
// Results go through a one-beat hold register and an output register, so the last
// flag is known before a beat leaves; when the receiver stalls, the pass simply
// pauses at the next result it has to hand over. Reset clears time, all fades,
// levels, the solenoid pulse and blink state, and loads the default configuration.
// Users must make configuration writes only while idle; the engine does not check.
module led_crossfade_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          req_type,
	input  logic [1:0]          strip,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [7:0]          white,
	input  logic [15:0]         fade_ms,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [3:0]          channel,
	output logic [12:0]         on_count,
	output logic [12:0]         off_count,
	output logic                solenoid_on,
	output logic                last
);
	import lce_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SOLCMD = 9'b000000010,
		S_FSCAN  = 9'b000000100,
		S_MUL    = 9'b000001000,
		S_DIV    = 9'b000010000,
		S_CHK    = 9'b000100000,
		S_SOL    = 9'b001000000,
		S_BLINK  = 9'b010000000,
		S_FLUSH  = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration.
	logic              invert_q;
	logic [15:0]       timeout_q;
	logic [15:0]       period_q;
	logic [LVL_W-1:0]  blink_lvl_q;

	// Engine state.
	logic [31:0]       now_q;
	logic [LVL_W-1:0]  from_q  [NCH];
	logic [LVL_W-1:0]  to_q    [NCH];
	logic [31:0]       start_q [NCH];
	logic [DUR_W-1:0]  dur_q   [NCH];
	logic [NCH-1:0]    active_q;
	logic [LVL_W-1:0]  level_q [NCH];
	logic [31:0]       deadline_q;
	logic              pulsing_q;
	logic              sol_q;
	logic              got_cmd_q;
	logic [31:0]       last_cmd_q;
	logic [31:0]       last_blink_q;
	logic              phase_q;

	// Pass control.
	logic [CH_W-1:0]   ch_q;
	logic [LVL_W-1:0]  val_q;
	logic              neg_q;

	// Result path: a hold beat in front of the output register.
	res_t              pend_q;
	logic              pend_valid_q;
	res_t              out_q;
	logic              out_valid_q;

	div_req_t          dreq;
	div_rsp_t          drsp;

	logic              accept;
	logic              out_free;
	logic              can_emit;
	logic              emit_req;
	res_t              emit_res;
	logic              flush_load;
	logic              out_load;
	res_t              pend_last;
	logic [31:0]       elapsed;
	logic              fade_done;
	logic [LVL_W-1:0]  mag;
	logic [31:0]       since;
	logic              blink_due;
	logic              sol_due;
	logic              last_ch;
	logic [31:0]       sol_diff;
	logic [LVL_W-1:0]  tgt [4];
	logic              pulse_cmd;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign can_emit = !pend_valid_q || out_free;
	assign last_ch  = (ch_q == CH_W'(NCH - 1));

	// The output register loads when a new result pushes the held beat out, or
	// when the pass ends and the held beat leaves as the last one.
	assign flush_load = (state_q == S_FLUSH) && pend_valid_q && out_free;
	assign out_load   = (emit_req && can_emit && pend_valid_q) || flush_load;

	always_comb begin
		pend_last = pend_q;
		pend_last.last = 1'b1;
	end

	assign elapsed   = now_q - start_q[ch_q];
	assign fade_done = (dur_q[ch_q] == '0) || (elapsed >= {16'b0, dur_q[ch_q]});
	assign mag       = (to_q[ch_q] >= from_q[ch_q]) ? (to_q[ch_q] - from_q[ch_q])
	                                                : (from_q[ch_q] - to_q[ch_q]);

	assign sol_diff  = now_q - deadline_q;
	assign sol_due   = pulsing_q && !sol_diff[31];
	assign since     = got_cmd_q ? (now_q - last_cmd_q) : now_q;
	assign blink_due = (since >= {16'b0, timeout_q}) &&
	                   ((now_q - last_blink_q) >= {16'b0, period_q});

	// Colour targets by channel offset: white, blue, green, red. All off drives zero.
	assign tgt[0] = (req_type == REQ_OFF) ? '0 : scale8(white);
	assign tgt[1] = (req_type == REQ_OFF) ? '0 : scale8(blue);
	assign tgt[2] = (req_type == REQ_OFF) ? '0 : scale8(green);
	assign tgt[3] = (req_type == REQ_OFF) ? '0 : scale8(red);
	assign pulse_cmd = (req_type == REQ_PULSE) && (fade_ms != '0);

	// The multiplier feeds the divider's operand register directly.
	assign dreq.start    = (state_q == S_MUL);
	assign dreq.dividend = PROD_W'(mag) * PROD_W'(elapsed[DUR_W-1:0]);
	assign dreq.divisor  = dur_q[ch_q];

	lce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		emit_req = 1'b0;
		emit_res = '0;
		case (state_q)
			S_SOLCMD: begin
				emit_req = 1'b1;
				emit_res.kind = 1'b1;
				emit_res.solenoid_on = 1'b1;
			end
			S_CHK: begin
				emit_req = (val_q != level_q[ch_q]);
				emit_res = pwm_word(ch_q, val_q, invert_q, sol_q);
			end
			S_SOL: begin
				emit_req = sol_due;
				emit_res.kind = 1'b1;
				emit_res.solenoid_on = 1'b0;
			end
			S_BLINK: begin
				emit_req = blink_due;
				emit_res = pwm_word('0, phase_q ? '0 : blink_lvl_q, invert_q, sol_q);
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			invert_q <= 1'b0;
			timeout_q <= 16'd5000;
			period_q <= 16'd900;
			blink_lvl_q <= 12'd200;
			now_q <= '0;
			for (int k = 0; k < NCH; k++) begin
				from_q[k] <= '0;
				to_q[k] <= '0;
				start_q[k] <= '0;
				dur_q[k] <= '0;
				level_q[k] <= '0;
			end
			active_q <= '0;
			deadline_q <= '0;
			pulsing_q <= 1'b0;
			sol_q <= 1'b0;
			got_cmd_q <= 1'b0;
			last_cmd_q <= '0;
			last_blink_q <= '0;
			phase_q <= 1'b0;
			ch_q <= '0;
			val_q <= '0;
			neg_q <= 1'b0;
			pend_q <= '0;
			pend_valid_q <= 1'b0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_INVERT:  invert_q <= cfg_wdata[0];
					CFG_TIMEOUT: timeout_q <= cfg_wdata;
					CFG_PERIOD:  period_q <= cfg_wdata;
					CFG_LEVEL:   blink_lvl_q <= cfg_wdata[LVL_W-1:0];
					default:     invert_q <= invert_q;
				endcase
			end

			if (out_load) begin
				out_q <= flush_load ? pend_last : pend_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// A new result pushes the held beat out, which is then known not to be last.
			if (emit_req && can_emit) begin
				pend_q <= emit_res;
				pend_valid_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q <= '0;
						state_q <= pulse_cmd ? S_SOLCMD : S_FSCAN;
						if (req_type == REQ_TICK) begin
							now_q <= now_q + 32'd1;
						end else begin
							got_cmd_q <= 1'b1;
							last_cmd_q <= now_q;
						end
						for (int k = 0; k < NCH; k++) begin
							if (((req_type == REQ_STRIP) && (int'(strip) == k / 4)) ||
							    (req_type == REQ_ALL) || (req_type == REQ_OFF)) begin
								from_q[k] <= level_q[k];
								to_q[k] <= tgt[k % 4];
								start_q[k] <= now_q;
								dur_q[k] <= fade_ms;
								active_q[k] <= 1'b1;
							end
						end
						if (pulse_cmd) begin
							sol_q <= 1'b1;
							pulsing_q <= 1'b1;
							deadline_q <= now_q + {16'b0, fade_ms};
						end
					end
				end
				S_SOLCMD: begin
					if (can_emit) begin
						state_q <= S_FSCAN;
					end
				end
				S_FSCAN: begin
					if (!active_q[ch_q]) begin
						ch_q <= last_ch ? '0 : ch_q + 1'b1;
						state_q <= last_ch ? S_SOL : S_FSCAN;
					end else if (fade_done) begin
						val_q <= to_q[ch_q];
						active_q[ch_q] <= 1'b0;
						state_q <= S_CHK;
					end else begin
						neg_q <= (to_q[ch_q] < from_q[ch_q]);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (drsp.done) begin
						// Truncation toward zero: divide magnitudes, then apply the sign.
						val_q <= neg_q ? (from_q[ch_q] - drsp.quotient)
						               : (from_q[ch_q] + drsp.quotient);
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!emit_req || can_emit) begin
						level_q[ch_q] <= val_q;
						ch_q <= last_ch ? '0 : ch_q + 1'b1;
						state_q <= last_ch ? S_SOL : S_FSCAN;
					end
				end
				S_SOL: begin
					if (!emit_req || can_emit) begin
						if (sol_due) begin
							sol_q <= 1'b0;
							pulsing_q <= 1'b0;
							deadline_q <= '0;
						end
						state_q <= S_BLINK;
					end
				end
				S_BLINK: begin
					if (!emit_req || can_emit) begin
						if (blink_due) begin
							last_blink_q <= now_q;
							phase_q <= !phase_q;
						end
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign channel     = out_q.channel;
	assign on_count    = out_q.on_count;
	assign off_count   = out_q.off_count;
	assign solenoid_on = out_q.solenoid_on;
	assign last        = out_q.last;

`ifndef SYNTHESIS
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("held result left behind at end of pass");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("engine stayed ready after taking a beat");
`endif

endmodule
